FILE: design/jdv_pkg.sv
// Package for the JSON document validator: parse phase codes, per-document
// flag record and the byte constants that the parser compares against.
// No dependencies.
`default_nettype none

package jdv_pkg;

  // Parse position within the document.
  typedef enum logic [3:0] {
    PH_LEAD         = 4'd0,
    PH_AFTER_OPEN   = 4'd1,
    PH_KEY          = 4'd2,
    PH_COLON        = 4'd3,
    PH_VALUE_START  = 4'd4,
    PH_VSTR         = 4'd5,
    PH_NESTED       = 4'd6,
    PH_PRIM         = 4'd7,
    PH_AFTER_VALUE  = 4'd8,
    PH_MEMBER_START = 4'd9,
    PH_TRAIL        = 4'd10
  } phase_t;

  // Parser flags that travel between the state register and the step logic.
  typedef struct packed {
    phase_t phase;
    logic   string_escape;
    logic   nested_in_string;
    logic   nested_escape;
    logic   nest_is_brace;
    logic   failed;
  } jdv_flags_t;

  localparam jdv_flags_t FLAGS_RESET = '{
    phase:            PH_LEAD,
    string_escape:    1'b0,
    nested_in_string: 1'b0,
    nested_escape:    1'b0,
    nest_is_brace:    1'b0,
    failed:           1'b0
  };

  // Byte constants.
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;

  // Register indexes of the configuration port.
  localparam logic REG_TOP_KIND = 1'b0;

endpackage

`default_nettype wire

FILE: design/jdv_step.sv
// Parser step for the JSON document validator: the next parser state and
// the document verdict for one byte. Depends on jdv_pkg.
`default_nettype none

module jdv_step #(
  parameter int DEPTH_BITS = 8
) (
  input  wire                     top_kind,
  input  wire  [7:0]              data_byte,
  input  wire                     last,
  input  jdv_pkg::jdv_flags_t     flags,
  input  wire  [DEPTH_BITS-1:0]   nest_depth,
  output jdv_pkg::jdv_flags_t     flags_next,
  output logic [DEPTH_BITS-1:0]   nest_depth_next,
  output logic                    valid_res
);
  import jdv_pkg::*;

  jdv_flags_t            nxt;
  logic [DEPTH_BITS-1:0] depth_nxt;
  logic [DEPTH_BITS-1:0] depth_dec;
  logic [7:0]            opener;
  logic [7:0]            closer;
  logic [7:0]            nest_open;
  logic [7:0]            nest_close;
  logic                  ws;
  logic                  sep;
  logic                  do_value_start;
  logic                  do_after_value;

  // Byte classes and the bracket pair of the top level and of a nested value.
  always_comb begin
    ws         = (data_byte == CH_SPACE) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
    sep        = (data_byte == CH_COMMA) || (data_byte == CH_RBRACE) ||
                 (data_byte == CH_RBRACK);
    opener     = top_kind ? CH_LBRACK : CH_LBRACE;
    closer     = top_kind ? CH_RBRACK : CH_RBRACE;
    nest_open  = flags.nest_is_brace ? CH_LBRACE : CH_LBRACK;
    nest_close = flags.nest_is_brace ? CH_RBRACE : CH_RBRACK;
    depth_dec  = (nest_depth != '0) ? nest_depth - 1'b1 : nest_depth;
  end

  // Consume one byte.
  always_comb begin
    nxt            = flags;
    depth_nxt      = nest_depth;
    do_value_start = 1'b0;
    do_after_value = 1'b0;

    case (flags.phase)
      PH_LEAD: begin
        if (!ws) begin
          if (data_byte == opener) nxt.phase = PH_AFTER_OPEN;
          else                     nxt.failed = 1'b1;
        end
      end
      PH_AFTER_OPEN: begin
        if (!ws) begin
          if (data_byte == closer) begin
            nxt.phase = PH_TRAIL;
          end else if (top_kind) begin
            do_value_start = 1'b1;
          end else if (data_byte == CH_QUOTE) begin
            nxt.string_escape = 1'b0;
            nxt.phase         = PH_KEY;
          end else begin
            nxt.failed = 1'b1;
          end
        end
      end
      PH_MEMBER_START: begin
        if (!ws) begin
          if (data_byte == CH_QUOTE) begin
            nxt.string_escape = 1'b0;
            nxt.phase         = PH_KEY;
          end else begin
            nxt.failed = 1'b1;
          end
        end
      end
      PH_KEY, PH_VSTR: begin
        if (flags.string_escape) begin
          nxt.string_escape = 1'b0;
        end else if (data_byte == CH_BSLASH) begin
          nxt.string_escape = 1'b1;
        end else if (data_byte == CH_QUOTE) begin
          nxt.phase = (flags.phase == PH_KEY) ? PH_COLON : PH_AFTER_VALUE;
        end else if (data_byte < CTRL_LIMIT) begin
          nxt.failed = 1'b1;
        end
      end
      PH_COLON: begin
        if (!ws) begin
          if (data_byte == CH_COLON) nxt.phase = PH_VALUE_START;
          else                       nxt.failed = 1'b1;
        end
      end
      PH_VALUE_START: begin
        do_value_start = !ws;
      end
      PH_NESTED: begin
        if (flags.nested_in_string) begin
          if (flags.nested_escape)          nxt.nested_escape = 1'b0;
          else if (data_byte == CH_BSLASH)  nxt.nested_escape = 1'b1;
          else if (data_byte == CH_QUOTE)   nxt.nested_in_string = 1'b0;
        end else if (data_byte == CH_QUOTE) begin
          nxt.nested_in_string = 1'b1;
          nxt.nested_escape    = 1'b0;
        end else if (data_byte == nest_open) begin
          if (nest_depth == '1) nxt.failed = 1'b1;
          else                  depth_nxt = nest_depth + 1'b1;
        end else if (data_byte == nest_close) begin
          depth_nxt = depth_dec;
          if (depth_dec == '0) nxt.phase = PH_AFTER_VALUE;
        end
      end
      PH_PRIM: begin
        do_after_value = sep;
      end
      PH_AFTER_VALUE: begin
        do_after_value = 1'b1;
      end
      PH_TRAIL: begin
        if (!ws) nxt.failed = 1'b1;
      end
      default: begin
        nxt.failed = 1'b1;
      end
    endcase

    // Start of a value in an array slot or after a colon.
    if (do_value_start) begin
      if (data_byte == CH_QUOTE) begin
        nxt.string_escape = 1'b0;
        nxt.phase         = PH_VSTR;
      end else if ((data_byte == CH_LBRACE) || (data_byte == CH_LBRACK)) begin
        nxt.nest_is_brace    = (data_byte == CH_LBRACE);
        depth_nxt            = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
        nxt.nested_in_string = 1'b0;
        nxt.nested_escape    = 1'b0;
        nxt.phase            = PH_NESTED;
      end else if (sep) begin
        nxt.failed = 1'b1;
      end else begin
        nxt.phase = PH_PRIM;
      end
    end

    // Separator or top-level closer after a value.
    if (do_after_value && !ws) begin
      if (data_byte == CH_COMMA)    nxt.phase = top_kind ? PH_VALUE_START : PH_MEMBER_START;
      else if (data_byte == closer) nxt.phase = PH_TRAIL;
      else                          nxt.failed = 1'b1;
    end

    // A failed document ignores every byte until its last one.
    if (flags.failed) begin
      nxt       = flags;
      depth_nxt = nest_depth;
    end
  end

  // Verdict on the last byte, and the return to the reset state.
  always_comb begin
    valid_res       = !nxt.failed && (nxt.phase == PH_TRAIL);
    flags_next      = last ? FLAGS_RESET : nxt;
    nest_depth_next = last ? '0 : depth_nxt;
  end

endmodule

`default_nettype wire

FILE: design/json_document_validator.sv
// Top level of the JSON document validator: input register, parser state,
// result register and the APB-style register port. Depends on jdv_pkg, jdv_step.
//
// Usage: the document is sent one byte per beat on the input channel
// (data_byte, last; in_valid/in_ready). The beat with last high ends the
// document and produces exactly one result beat on the output channel
// (valid_res; out_valid/out_ready); other beats produce none. valid_res is 1
// when the document was one well-formed top-level object (top_kind = 0) or
// array (top_kind = 1), optionally wrapped in whitespace.
// Timing: a beat accepted at a clock edge is parsed in the following cycle
// from the input register; the result of a last beat is then written to the
// result register and shown there on out_valid and valid_res.
// Throughput: one byte per cycle, unless a last beat is held as below.
// Stalls: a waiting result does not stop the stream; only a further last
// beat holds in the input register until the waiting result is taken.
// Reset (synchronous, rst high) empties both registers, clears the parser
// state and sets top_kind to 0. top_kind should be written between documents;
// it keeps its value from one document to the next.
`default_nettype none

module json_document_validator #(
  parameter int DEPTH_BITS = 8
) (
  input  wire         clk,
  input  wire         rst,
  // Byte stream.
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  data_byte,
  input  wire         last,
  // Verdict.
  output logic        out_valid,
  input  wire         out_ready,
  output logic        valid_res,
  // Register port.
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import jdv_pkg::*;

  logic                  top_kind;
  logic                  s1_valid;
  logic [7:0]            s1_byte;
  logic                  s1_last;
  jdv_flags_t            flags;
  jdv_flags_t            flags_next;
  logic [DEPTH_BITS-1:0] nest_depth;
  logic [DEPTH_BITS-1:0] nest_depth_next;
  logic                  step_res;
  logic                  advance;
  logic                  reg_index;

  // Register port: one register, decoded from paddr[2] alone, at byte address 0.
  assign pready    = 1'b1;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      top_kind <= 1'b0;
    end else if (psel && penable && pwrite && pready && (reg_index == REG_TOP_KIND)) begin
      top_kind <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_TOP_KIND) prdata[0] = top_kind;
  end

  // The held byte moves on unless it would produce a result while one waits.
  assign advance  = s1_valid && !(s1_last && out_valid && !out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
      s1_last <= last;
    end
  end

  // Parser step.
  jdv_step #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_step (
    .top_kind        (top_kind),
    .data_byte       (s1_byte),
    .last            (s1_last),
    .flags           (flags),
    .nest_depth      (nest_depth),
    .flags_next      (flags_next),
    .nest_depth_next (nest_depth_next),
    .valid_res       (step_res)
  );

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= FLAGS_RESET;
      nest_depth <= '0;
    end else if (advance) begin
      flags      <= flags_next;
      nest_depth <= nest_depth_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      valid_res <= step_res;
    end
  end

  // A last beat never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && out_valid && !out_ready) |-> (!advance && !in_ready))
    else $error("last beat advanced over a waiting result");

  // The end of a document returns the parser to its reset state.
  a_doc_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> ((flags.phase == PH_LEAD) && !flags.failed &&
                              (nest_depth == '0)))
    else $error("parser state not cleared after last beat");

  // Every last beat yields a result beat.
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> out_valid)
    else $error("no result after last beat");

  // A failed document stays failed until its last byte.
  a_failed_sticks: assert property (@(posedge clk) disable iff (rst)
    (advance && flags.failed && !s1_last) |=> flags.failed)
    else $error("failure flag dropped mid-document");

endmodule

`default_nettype wire
